@@ hw/rtl/sorted_priority_queue_defines.svh @@
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Checks a property on every rising edge of clk_i while out of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned SCORE_W   = 10;
  localparam int unsigned CAP_REG_W = 7;
  localparam int unsigned COUNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W     = (COUNT_W > CAP_REG_W) ? COUNT_W : CAP_REG_W;

  localparam logic [SCORE_W-1:0]   MAX_SCORE = SCORE_W'(1000);
  localparam logic [CAP_REG_W-1:0] CAP_RESET = CAP_REG_W'(64);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_SCORE = 2'd3
  } spq_status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } spq_op_e;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [TAG_BITS-1:0] tag;
  } spq_entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic       insert;
    logic       remove;
    spq_entry_t data;
  } spq_cmd_t;

endpackage

@@ hw/rtl/spq_if.sv @@
// Handshake channels of the sorted priority queue: request and result.
interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [spq_pkg::SCORE_W-1:0]   score;
  logic [spq_pkg::TAG_BITS-1:0]  tag;

  modport source (output valid, operation, score, tag, input ready);
  modport sink   (input valid, operation, score, tag, output ready);
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          removed_valid;
  logic [spq_pkg::SCORE_W-1:0]   removed_score;
  logic [spq_pkg::TAG_BITS-1:0]  removed_tag;
  logic [spq_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, status, removed_valid, removed_score, removed_tag,
                  entry_count, input ready);
  modport sink   (input valid, status, removed_valid, removed_score, removed_tag,
                  entry_count, output ready);
endinterface

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  logic                occupied_i,
  input  logic                prev_ge_i,
  input  spq_pkg::spq_entry_t prev_i,
  input  spq_pkg::spq_entry_t next_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic                ge_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // The held entry stays ahead of the newcomer when its score is at least as high.
  assign ge_o    = occupied_i && (entry_q.score >= cmd_i.data.score);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert) begin
      if (!ge_o) begin
        entry_d = prev_ge_i ? cmd_i.data : prev_i;
      end
    end else if (cmd_i.remove) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Sorted priority queue top level: a chain of entry cells with a result register.
//
// Usage: requests arrive as beats on in_if (operation, score, tag) and each
// accepted beat yields exactly one result beat on out_if (status, removed
// entry, entry count). An insert slots the entry behind every held entry of
// greater or equal score; a delete hands back the head of the chain.
// The result beat is valid in the cycle after the request beat is taken.
// Every cell compares its score with the newcomer and shifts in parallel,
// so one beat per cycle is sustained while the receiver keeps up; the
// single result register sets that figure, and a new request is taken
// whenever that register is empty or is being drained in the same cycle.
// When the receiver stalls, the result waits in its register and in_if.ready
// drops until it is taken, so no result is lost or repeated.
// cfg_we_i / cfg_wdata_i write the capacity register; the user must write it
// only while the block is idle, which it does not enforce. Values above the
// chain length behave as the chain length. Reset empties the queue, clears
// the pending result and sets the capacity to the full chain. Cell contents
// are not cleared: only cells below the entry count are ever read.
module sorted_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spq_pkg::CAP_REG_W-1:0]     cfg_wdata_i,
  spq_in_if.sink                            in_if,
  spq_out_if.source                         out_if
);
  import spq_pkg::*;

  // Result beat held until the receiver takes it.
  typedef struct packed {
    spq_status_e         status;
    logic                removed_valid;
    logic [SCORE_W-1:0]  removed_score;
    logic [TAG_BITS-1:0] removed_tag;
    logic [COUNT_W-1:0]  entry_count;
  } spq_result_t;

  logic [CAP_REG_W-1:0] cap_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 out_valid_q;
  spq_result_t          res_q, res_d;

  logic        in_fire, out_fire;
  logic        is_insert, full, insert_ok, delete_ok;
  spq_cmd_t    cmd;
  spq_entry_t  entry [CAPACITY];
  logic        ge    [CAPACITY];

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_valid_q && out_if.ready;

  // The request side is open whenever the result register is free or draining.
  assign in_if.ready = !out_valid_q || out_if.ready;

  // Full when the count meets the programmed capacity or the chain length.
  assign is_insert = (spq_op_e'(in_if.operation) == OP_INSERT);
  assign full      = (CMP_W'(count_q) >= CMP_W'(cap_q)) ||
                     (count_q == COUNT_W'(CAPACITY));
  assign insert_ok = is_insert && !full && (in_if.score <= MAX_SCORE);
  assign delete_ok = !is_insert && (count_q != '0);

  assign cmd.insert     = in_fire && insert_ok;
  assign cmd.remove     = in_fire && delete_ok;
  assign cmd.data.score = in_if.score;
  assign cmd.data.tag   = in_if.tag;

  // The chain: each cell sees its left and right neighbour and the broadcast
  // command. The first cell has no left neighbour, so an insert that beats
  // its score always lands there; the last cell has no right neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       occupied;
    logic       prev_ge;
    spq_entry_t prev_entry;
    spq_entry_t next_entry;

    assign occupied = (COUNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_entry = entry[0];
    end else begin : g_body
      assign prev_ge    = ge[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (occupied),
      .prev_ge_i  (prev_ge),
      .prev_i     (prev_entry),
      .next_i     (next_entry),
      .entry_o    (entry[i]),
      .ge_o       (ge[i])
    );
  end

  // Next count and the result of the request currently offered.
  always_comb begin
    count_d = count_q;
    if (cmd.insert) begin
      count_d = count_q + COUNT_W'(1);
    end else if (cmd.remove) begin
      count_d = count_q - COUNT_W'(1);
    end

    res_d               = '0;
    res_d.status        = ST_OK;
    res_d.entry_count   = count_d;
    if (is_insert) begin
      if (full) begin
        res_d.status = ST_OVERFLOW;
      end else if (in_if.score > MAX_SCORE) begin
        res_d.status = ST_BAD_SCORE;
      end
    end else if (count_q == '0) begin
      res_d.status = ST_UNDERFLOW;
    end else begin
      res_d.removed_valid = 1'b1;
      res_d.removed_score = entry[0].score;
      res_d.removed_tag   = entry[0].tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = res_q.status;
  assign out_if.removed_valid = res_q.removed_valid;
  assign out_if.removed_score = res_q.removed_score;
  assign out_if.removed_tag   = res_q.removed_tag;
  assign out_if.entry_count   = res_q.entry_count;

  // Conditions watched by the checks below.
  logic head_sorted;
  logic removal_ok;

  assign head_sorted = (count_q < COUNT_W'(2)) || (entry[0].score >= entry[1].score);
  assign removal_ok  = !out_valid_q || !res_q.removed_valid || (res_q.status == ST_OK);

`include "sorted_priority_queue_defines.svh"

  `SPQ_ASSERT(a_count_bound, count_q <= COUNT_W'(CAPACITY), "entry count beyond chain length")
  `SPQ_ASSERT(a_head_order, head_sorted, "head cells out of order")
  `SPQ_ASSERT(a_removed_ok, removal_ok, "removed entry with failing status")
  `SPQ_ASSERT_NEXT(a_ins_count, cmd.insert, count_q == $past(count_q) + COUNT_W'(1), "insert lost")

endmodule
